[rtl/core/websocket_frame_deframer_defines.svh]
// Assertion macros for the deframer modules; only wsd_parser uses them.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on i_clk while out of reset.
`define WSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk while out of reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/wsd_pkg.sv]
// Types and constants shared by the deframer modules.
package wsd_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LEN64      = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] OPC_DATA_MAX  = 4'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic       has_data;
        logic [7:0] payload_byte;
        logic [1:0] frame_opcode;
        logic       last_of_frame;
        logic [1:0] status;
    } t_result;

endpackage

[rtl/core/wsd_in_stage.sv]
// Input register that holds one received byte until the parser takes it.
module wsd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wsd_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output wsd_pkg::t_in_item o_item
);

    logic              r_valid;
    wsd_pkg::t_in_item r_item;
    logic              w_load;

    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/core/wsd_parser.sv]
// Frame header state machine, payload unmasking and result formation.
`include "websocket_frame_deframer_defines.svh"

module wsd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsd_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_res_valid,
    output wsd_pkg::t_result  o_res
);

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_KEY     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DISCARD = 6'b100000
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [1:0]  r_sub_count,   n_sub_count;
    logic        r_fin,         n_fin;
    logic [3:0]  r_opcode,      n_opcode;
    logic        r_masked,      n_masked;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_bytes_left,  n_bytes_left;
    logic [31:0] r_mask_key,    n_mask_key;
    logic [1:0]  r_key_index,   n_key_index;

    logic        w_is_data;
    logic        w_after_len;
    logic        w_start_pay;
    logic        w_emit;
    logic [15:0] w_left_dec;
    logic [7:0]  w_key_byte;
    logic [6:0]  w_len;
    logic [7:0]  w_b;
    wsd_pkg::t_result w_res;

    assign w_b        = i_item.data_byte;
    assign w_len      = w_b[6:0];
    assign w_is_data  = r_fin && (r_opcode <= wsd_pkg::OPC_DATA_MAX);
    assign w_left_dec = r_bytes_left - 16'd1;

    always_comb begin
        case (r_key_index)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_sub_count   = r_sub_count;
        n_fin         = r_fin;
        n_opcode      = r_opcode;
        n_masked      = r_masked;
        n_length_high = r_length_high;
        n_bytes_left  = r_bytes_left;
        n_mask_key    = r_mask_key;
        n_key_index   = r_key_index;
        w_after_len   = 1'b0;
        w_start_pay   = 1'b0;
        w_emit        = 1'b0;
        w_res         = '0;

        case (r_phase)
            PH_HDR1: begin
                n_masked = w_b[7];
                if (w_len == wsd_pkg::LEN_EXT64) begin
                    w_emit       = 1'b1;
                    w_res.status = wsd_pkg::ST_LEN64;
                    n_phase      = PH_DISCARD;
                end else if (w_len == wsd_pkg::LEN_EXT16) begin
                    n_phase     = PH_LEN;
                    n_sub_count = 2'd0;
                end else begin
                    n_bytes_left = {9'd0, w_len};
                    w_after_len  = 1'b1;
                end
            end
            PH_LEN: begin
                if (r_sub_count == 2'd0) begin
                    n_length_high = w_b;
                    n_sub_count   = 2'd1;
                end else begin
                    n_bytes_left = {r_length_high, w_b};
                    w_after_len  = 1'b1;
                end
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], w_b};
                if (r_sub_count == 2'd3) begin
                    w_start_pay = 1'b1;
                end else begin
                    n_sub_count = r_sub_count + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                n_bytes_left = w_left_dec;
                n_key_index  = r_key_index + 2'd1;
                if (w_is_data) begin
                    w_emit              = 1'b1;
                    w_res.has_data      = 1'b1;
                    w_res.payload_byte  = w_b ^ w_key_byte;
                    w_res.last_of_frame = (w_left_dec == 16'd0);
                end
                if (w_left_dec == 16'd0) begin
                    n_phase = PH_HDR0;
                end
            end
            PH_DISCARD: begin
                n_phase = PH_DISCARD;
            end
            default: begin
                // First header byte; also recovers from any illegal phase code.
                n_fin         = w_b[7];
                n_opcode      = w_b[3:0];
                n_masked      = 1'b0;
                n_length_high = 8'd0;
                n_bytes_left  = 16'd0;
                n_mask_key    = 32'd0;
                n_key_index   = 2'd0;
                n_sub_count   = 2'd0;
                n_phase       = PH_HDR1;
            end
        endcase

        if (w_after_len) begin
            if (n_masked) begin
                n_phase     = PH_KEY;
                n_sub_count = 2'd0;
            end else begin
                w_start_pay = 1'b1;
            end
        end

        if (w_start_pay) begin
            n_key_index = 2'd0;
            if (n_bytes_left == 16'd0) begin
                // An empty final data frame still produces one end-of-frame marker.
                n_phase = PH_HDR0;
                if (w_is_data) begin
                    w_emit              = 1'b1;
                    w_res.last_of_frame = 1'b1;
                end
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end

        if (i_item.end_of_buffer) begin
            if (n_phase != PH_HDR0 && n_phase != PH_DISCARD) begin
                w_emit       = 1'b1;
                w_res        = '0;
                w_res.status = wsd_pkg::ST_INCOMPLETE;
            end
            n_phase = PH_HDR0;
        end

        // The opcode reported is that of the frame in hand when it is a final data frame.
        if (n_fin && (n_opcode <= wsd_pkg::OPC_DATA_MAX)) begin
            w_res.frame_opcode = n_opcode[1:0];
        end else begin
            w_res.frame_opcode = 2'd0;
        end
    end

    assign o_res_valid = i_valid && w_emit;
    assign o_res       = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

    // The frame fields are always rewritten by the first header byte before use.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_sub_count   <= n_sub_count;
            r_fin         <= n_fin;
            r_opcode      <= n_opcode;
            r_masked      <= n_masked;
            r_length_high <= n_length_high;
            r_bytes_left  <= n_bytes_left;
            r_mask_key    <= n_mask_key;
            r_key_index   <= n_key_index;
        end
    end

    `WSD_ASSERT_IMP(a_payload_nonempty, r_phase == PH_PAYLOAD, r_bytes_left != 16'd0,
        "payload phase entered with no bytes left")
    `WSD_ASSERT_NEXT(a_eob_returns_idle, i_advance && i_item.end_of_buffer,
        r_phase == PH_HDR0, "end of buffer did not return the parser to the header")
    `WSD_ASSERT_IMP(a_error_has_no_data, o_res_valid && o_res.status != wsd_pkg::ST_OK,
        !o_res.has_data && o_res.payload_byte == 8'd0, "error transaction carries data")
    `WSD_ASSERT_IMP(a_data_from_payload, o_res_valid && o_res.has_data,
        r_phase == PH_PAYLOAD, "payload byte produced outside the payload phase")

endmodule

[rtl/core/wsd_out_stage.sv]
// Result register that holds one result until the downstream side takes it.
module wsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output wsd_pkg::t_result o_res
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    assign o_valid = r_valid;
    assign o_free  = !r_valid || i_ready;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/websocket_frame_deframer.sv]
// WebSocket receive deframer: one input byte per transaction, unmasked payload bytes out.
// Throughput is one byte per clock cycle unless output back-pressure stalls it; a byte
// passes through an input register, then a single pass of header parsing and payload
// unmasking, and into the result register, which presents the result. Only payload
// bytes of final data frames, empty-frame markers and status reports (64-bit length,
// incomplete frame) produce an output transaction; all other bytes are consumed
// silently. Back-pressure on the output only stalls the input when the result register
// is full and not being taken.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_has_data,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_frame_opcode,
    output logic       o_last_of_frame,
    output logic [1:0] o_status
);

    wsd_pkg::t_in_item w_in_item;
    wsd_pkg::t_in_item w_stage_item;
    wsd_pkg::t_result  w_res;
    wsd_pkg::t_result  w_out_res;
    logic              w_stage_valid;
    logic              w_res_valid;
    logic              w_out_free;
    logic              w_advance;

    assign w_in_item.data_byte     = i_data_byte;
    assign w_in_item.end_of_buffer = i_end_of_buffer;

    // A held byte moves on whenever the result register can take whatever it yields.
    assign w_advance = w_stage_valid && w_out_free;

    wsd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .i_advance   (w_advance),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res_valid),
        .i_res   (w_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign o_has_data      = w_out_res.has_data;
    assign o_payload_byte  = w_out_res.payload_byte;
    assign o_frame_opcode  = w_out_res.frame_opcode;
    assign o_last_of_frame = w_out_res.last_of_frame;
    assign o_status        = w_out_res.status;

endmodule
